>>> src/owm_pkg.sv
// shared types and constants for the single-wire bus master
package owm_pkg;

    // configuration register layout
    localparam int unsigned CFG_W   = 10;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_TAIL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_LOW     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_LOW      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT          = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE   = 3'd6;

    // register reset values in microseconds
    localparam logic [CFG_W-1:0] RST_RESET_LOW     = 10'd480;
    localparam logic [CFG_W-1:0] RST_PRESENCE_WAIT = 10'd70;
    localparam logic [CFG_W-1:0] RST_RESET_TAIL    = 10'd410;
    localparam logic [CFG_W-1:0] RST_SHORT_LOW     = 10'd6;
    localparam logic [CFG_W-1:0] RST_LONG_LOW      = 10'd60;
    localparam logic [CFG_W-1:0] RST_SLOT          = 10'd70;
    localparam logic [CFG_W-1:0] RST_READ_SAMPLE   = 10'd9;

    // command opcodes
    localparam int unsigned OP_W = 3;
    localparam logic [OP_W-1:0] OP_TICK       = 3'd0;
    localparam logic [OP_W-1:0] OP_RESET      = 3'd1;
    localparam logic [OP_W-1:0] OP_WRITE_BYTE = 3'd2;
    localparam logic [OP_W-1:0] OP_READ_BYTE  = 3'd3;
    localparam logic [OP_W-1:0] OP_READ_BIT   = 3'd4;

    localparam int unsigned BITS_W = 4;
    localparam logic [BITS_W-1:0] BITS_BYTE = 4'd8;
    localparam logic [BITS_W-1:0] BITS_ONE  = 4'd1;

    // operation phase
    typedef enum logic [6:0] {
        PH_IDLE      = 7'b0000001,
        PH_RST_LOW   = 7'b0000010,
        PH_RST_WAIT  = 7'b0000100,
        PH_RST_TAIL  = 7'b0001000,
        PH_WRITE     = 7'b0010000,
        PH_READ_BYTE = 7'b0100000,
        PH_READ_BIT  = 7'b1000000
    } t_phase;

endpackage

>>> src/owm_cmd_if.sv
// command and tick channel into the bus master
interface owm_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [7:0] data_byte;
    logic       line_level;

    modport source (output valid, output opcode, output data_byte, output line_level,
                    input ready);
    modport sink (input valid, input opcode, input data_byte, input line_level,
                  output ready);
endinterface

>>> src/owm_res_if.sv
// result channel out of the bus master
interface owm_res_if;
    logic       valid;
    logic       ready;
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_data;
    logic       rejected;

    modport source (output valid, output drive_low, output busy_res, output done_res,
                    output presence, output read_data, output rejected, input ready);
    modport sink (input valid, input drive_low, input busy_res, input done_res,
                  input presence, input read_data, input rejected, output ready);
endinterface

>>> src/one_wire_bus_master.sv
// single-wire bus master: timing state machine, config registers and result register
//
//  channel   | dir | beat contents
//  ----------+-----+-----------------------------------------------------------
//  i_cmd     | in  | opcode, data_byte, line_level (one beat per bus microsecond)
//  o_res     | out | drive_low, busy_res, done_res, presence, read_data, rejected
//  i_cfg_*   | in  | write enable, register index, 10-bit timing value
//
// one beat accepted per clock while i_cmd is not stalled; its result is in the output register on the next clock.
// the phase/timer update and the result are one pass of logic from the accepted beat.
// i_cmd stalls only while a result sits in the output register and o_res.ready is low.
// synchronous active-low reset puts the phase at idle and the timings at their defaults.
module one_wire_bus_master #(
    parameter int unsigned TIMER_BITS = 10
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    owm_cmd_if.sink                          i_cmd,
    owm_res_if.source                        o_res,
    input  logic                             i_cfg_we,
    input  logic [owm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [owm_pkg::CFG_W-1:0]        i_cfg_data
);

    localparam int unsigned CW = owm_pkg::CFG_W;
    // wide enough for the sum of two timings and for any timer value
    localparam int unsigned XW = (TIMER_BITS > CW) ? TIMER_BITS + 1 : CW + 1;
    localparam logic [TIMER_BITS-1:0] TMAX = '1;

    // saturate a phase length to the timer, zero acting as one
    function automatic logic [TIMER_BITS-1:0] clamp_len(input logic [CW-1:0] v);
        logic [XW-1:0] ext;
        logic [TIMER_BITS-1:0] res;
        ext = XW'(v);
        if (ext > XW'(TMAX)) begin
            res = TMAX;
        end else begin
            res = ext[TIMER_BITS-1:0];
        end
        if (res == '0) begin
            res = TIMER_BITS'(1);
        end
        return res;
    endfunction

    // saturate a low time to the timer
    function automatic logic [TIMER_BITS-1:0] clamp_low(input logic [CW-1:0] v);
        logic [XW-1:0] ext;
        ext = XW'(v);
        if (ext > XW'(TMAX)) begin
            return TMAX;
        end
        return ext[TIMER_BITS-1:0];
    endfunction

    // configuration registers
    logic [CW-1:0] r_reset_low, r_presence_wait, r_reset_tail;
    logic [CW-1:0] r_short_low, r_long_low, r_slot, r_read_sample;

    // operation state
    owm_pkg::t_phase              r_phase, n_phase;
    logic [TIMER_BITS-1:0]        r_elapsed, n_elapsed;
    logic [owm_pkg::BITS_W-1:0]   r_bits_left, n_bits_left;
    logic [7:0]                   r_shifter, n_shifter;
    logic                         r_presence, n_presence;

    // result register
    logic       r_out_valid;
    logic       r_drive, n_drive;
    logic       r_done, n_done;
    logic       r_rej, n_rej;
    logic [7:0] r_rdata, n_rdata;

    logic                  in_accept;
    logic                  is_cmd;
    logic                  advance;
    logic [TIMER_BITS-1:0] slot_len;
    logic [TIMER_BITS-1:0] slot_m1;
    logic [TIMER_BITS-1:0] low_len;
    logic [XW-1:0]         at_sum;
    logic [TIMER_BITS-1:0] at_pt;

    // skid: accept when the output register is free or being drained
    assign i_cmd.ready = !r_out_valid || o_res.ready;
    assign in_accept   = i_cmd.valid && i_cmd.ready;

    assign is_cmd = (i_cmd.opcode == owm_pkg::OP_RESET)
                 || (i_cmd.opcode == owm_pkg::OP_WRITE_BYTE)
                 || (i_cmd.opcode == owm_pkg::OP_READ_BYTE)
                 || (i_cmd.opcode == owm_pkg::OP_READ_BIT);

    // slot timing values
    assign slot_len = clamp_len(r_slot);
    assign slot_m1  = slot_len - TIMER_BITS'(1);
    assign at_sum   = XW'(r_short_low) + XW'(r_read_sample);
    assign at_pt    = (at_sum > XW'(slot_m1)) ? slot_m1 : at_sum[TIMER_BITS-1:0];

    always_comb begin
        if (r_phase == owm_pkg::PH_WRITE && !r_shifter[0]) begin
            low_len = clamp_low(r_long_low);
        end else begin
            low_len = clamp_low(r_short_low);
        end
    end

    // next state and result for the accepted beat
    always_comb begin
        n_phase     = r_phase;
        n_elapsed   = r_elapsed;
        n_bits_left = r_bits_left;
        n_shifter   = r_shifter;
        n_presence  = r_presence;
        n_drive     = 1'b0;
        n_done      = 1'b0;
        n_rej       = 1'b0;
        n_rdata     = '0;
        advance     = 1'b1;

        if (r_phase != owm_pkg::PH_IDLE && is_cmd) begin
            n_rej = 1'b1;
        end

        unique case (r_phase)
            owm_pkg::PH_IDLE: begin
                advance = 1'b0;
                if (is_cmd) begin
                    n_elapsed = '0;
                    case (i_cmd.opcode)
                        owm_pkg::OP_RESET: begin
                            n_phase = owm_pkg::PH_RST_LOW;
                        end
                        owm_pkg::OP_WRITE_BYTE: begin
                            n_phase     = owm_pkg::PH_WRITE;
                            n_shifter   = i_cmd.data_byte;
                            n_bits_left = owm_pkg::BITS_BYTE;
                        end
                        owm_pkg::OP_READ_BYTE: begin
                            n_phase     = owm_pkg::PH_READ_BYTE;
                            n_shifter   = '0;
                            n_bits_left = owm_pkg::BITS_BYTE;
                        end
                        default: begin
                            n_phase     = owm_pkg::PH_READ_BIT;
                            n_shifter   = '0;
                            n_bits_left = owm_pkg::BITS_ONE;
                        end
                    endcase
                end
            end
            owm_pkg::PH_RST_LOW: begin
                n_drive = 1'b1;
                if (r_elapsed >= clamp_len(r_reset_low) - TIMER_BITS'(1)) begin
                    n_phase   = owm_pkg::PH_RST_WAIT;
                    n_elapsed = '0;
                    advance   = 1'b0;
                end
            end
            owm_pkg::PH_RST_WAIT: begin
                if (r_elapsed >= clamp_len(r_presence_wait) - TIMER_BITS'(1)) begin
                    n_phase   = owm_pkg::PH_RST_TAIL;
                    n_elapsed = '0;
                    advance   = 1'b0;
                end
            end
            owm_pkg::PH_RST_TAIL: begin
                // presence sample on the first tail microsecond
                if (r_elapsed == '0) begin
                    n_presence = !i_cmd.line_level;
                end
                if (r_elapsed >= clamp_len(r_reset_tail) - TIMER_BITS'(1)) begin
                    n_phase   = owm_pkg::PH_IDLE;
                    n_elapsed = '0;
                    n_done    = 1'b1;
                    advance   = 1'b0;
                end
            end
            owm_pkg::PH_WRITE, owm_pkg::PH_READ_BYTE, owm_pkg::PH_READ_BIT: begin
                if (r_elapsed < low_len) begin
                    n_drive = 1'b1;
                end
                // read sample point
                if (r_phase != owm_pkg::PH_WRITE && r_elapsed == at_pt) begin
                    if (r_phase == owm_pkg::PH_READ_BYTE) begin
                        n_shifter = {i_cmd.line_level, r_shifter[7:1]};
                    end else begin
                        n_shifter = {7'd0, i_cmd.line_level};
                    end
                end
                // end of slot
                if (r_elapsed >= slot_m1) begin
                    if (r_phase == owm_pkg::PH_WRITE) begin
                        n_shifter = {1'b0, r_shifter[7:1]};
                    end
                    n_bits_left = r_bits_left - owm_pkg::BITS_W'(1);
                    n_elapsed   = '0;
                    advance     = 1'b0;
                    if (n_bits_left == '0) begin
                        if (r_phase == owm_pkg::PH_READ_BYTE) begin
                            n_rdata = n_shifter;
                        end else if (r_phase == owm_pkg::PH_READ_BIT) begin
                            n_rdata = {7'd0, n_shifter[0]};
                        end
                        n_phase = owm_pkg::PH_IDLE;
                        n_done  = 1'b1;
                    end
                end
            end
            default: begin
                n_phase   = owm_pkg::PH_IDLE;
                n_elapsed = '0;
                advance   = 1'b0;
            end
        endcase

        if (advance) begin
            n_elapsed = r_elapsed + TIMER_BITS'(1);
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reset_low     <= owm_pkg::RST_RESET_LOW;
            r_presence_wait <= owm_pkg::RST_PRESENCE_WAIT;
            r_reset_tail    <= owm_pkg::RST_RESET_TAIL;
            r_short_low     <= owm_pkg::RST_SHORT_LOW;
            r_long_low      <= owm_pkg::RST_LONG_LOW;
            r_slot          <= owm_pkg::RST_SLOT;
            r_read_sample   <= owm_pkg::RST_READ_SAMPLE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                owm_pkg::REG_RESET_LOW:     r_reset_low     <= i_cfg_data;
                owm_pkg::REG_PRESENCE_WAIT: r_presence_wait <= i_cfg_data;
                owm_pkg::REG_RESET_TAIL:    r_reset_tail    <= i_cfg_data;
                owm_pkg::REG_SHORT_LOW:     r_short_low     <= i_cfg_data;
                owm_pkg::REG_LONG_LOW:      r_long_low      <= i_cfg_data;
                owm_pkg::REG_SLOT:          r_slot          <= i_cfg_data;
                owm_pkg::REG_READ_SAMPLE:   r_read_sample   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // operation state update on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= owm_pkg::PH_IDLE;
            r_elapsed   <= '0;
            r_bits_left <= '0;
            r_shifter   <= '0;
            r_presence  <= 1'b0;
        end else if (in_accept) begin
            r_phase     <= n_phase;
            r_elapsed   <= n_elapsed;
            r_bits_left <= n_bits_left;
            r_shifter   <= n_shifter;
            r_presence  <= n_presence;
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_drive <= n_drive;
            r_done  <= n_done;
            r_rej   <= n_rej;
            r_rdata <= n_rdata;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.drive_low = r_drive;
    assign o_res.busy_res  = (r_phase != owm_pkg::PH_IDLE);
    assign o_res.done_res  = r_done;
    assign o_res.presence  = r_presence;
    assign o_res.read_data = r_rdata;
    assign o_res.rejected  = r_rej;

`ifndef NO_ASSERTIONS
    // a finished operation leaves the master idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.done_res) |-> !o_res.busy_res)
        else $error("done result while still busy");

    // a beat taken while idle is never rejected
    a_no_reject_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && r_phase == owm_pkg::PH_IDLE) |=> !r_rej)
        else $error("beat rejected while idle");

    // slot phases always have bits remaining
    a_bits_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == owm_pkg::PH_WRITE || r_phase == owm_pkg::PH_READ_BYTE
         || r_phase == owm_pkg::PH_READ_BIT) |-> (r_bits_left != '0))
        else $error("slot phase with no bits left");
`endif

endmodule
